// ===== rtl/vcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex contour classifier package
// Shared payload types, register indexes, reset values and pipeline widths.
// ----------------------------------------------------------------------------
package vcc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  localparam logic [CFG_IDX_W-1:0] REG_EYE_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTOUR_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUGGEST_LIM = 3'd4;

  localparam logic [31:0] EYE_X_RST       = 32'd1966080;
  localparam logic [31:0] EYE_Y_RST       = 32'd0;
  localparam logic [31:0] EYE_Z_RST       = 32'd0;
  localparam logic [62:0] CONTOUR_LIM_RST = 63'd214748365;
  localparam logic [62:0] SUGGEST_LIM_RST = 63'd214748;

  localparam logic [63:0] Q64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Quotient width of the cos^2 divider: Q0.32 plus the bit for exactly 1.0.
  localparam int Q_W   = 33;
  localparam int NUM_W = 124;
  localparam logic [Q_W-1:0] COS_ONE = 33'h1_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic signed [31:0] peer_x;
    logic signed [31:0] peer_y;
    logic signed [31:0] peer_z;
    logic signed [63:0] curv_max;
    logic signed [63:0] curv_min;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic               on_contour;
    logic               on_suggestive;
    logic signed [63:0] view_dot;
    logic signed [63:0] radial_curv;
    logic               last_out;
  } result_t;

  // Values that ride along the pipeline with each vertex.
  typedef struct packed {
    logic signed [63:0] k1;
    logic signed [63:0] k2;
    logic signed [63:0] d;
    logic               cont;
    logic               ok;
    logic               last;
  } side_t;

endpackage

// ===== rtl/vertex_contour_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Vertex contour classifier core
// Throughput: one vertex per cycle; busy is always low and nothing stalls.
// Start-to-done depth is set by the 33-stage cos^2 divider and the wide multiply splits.
// Synchronous reset empties the pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
module vertex_contour_classifier_core
  import vcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  vertex_t               vertex,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output result_t               result
);

  // Configuration registers.
  logic [31:0] eye_x, eye_y, eye_z;
  logic [62:0] contour_lim, suggest_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x       <= EYE_X_RST;
      eye_y       <= EYE_Y_RST;
      eye_z       <= EYE_Z_RST;
      contour_lim <= CONTOUR_LIM_RST;
      suggest_lim <= SUGGEST_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_EYE_X:       eye_x <= cfg_data[31:0];
        REG_EYE_Y:       eye_y <= cfg_data[31:0];
        REG_EYE_Z:       eye_z <= cfg_data[31:0];
        REG_CONTOUR_LIM: contour_lim <= cfg_data;
        REG_SUGGEST_LIM: suggest_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic signed [31:0] eye [3], pos [3], nrm [3], peer [3];
  always_comb begin
    eye[0]  = eye_x;         eye[1]  = eye_y;         eye[2]  = eye_z;
    pos[0]  = vertex.pos_x;  pos[1]  = vertex.pos_y;  pos[2]  = vertex.pos_z;
    nrm[0]  = vertex.norm_x; nrm[1]  = vertex.norm_y; nrm[2]  = vertex.norm_z;
    peer[0] = vertex.peer_x; peer[1] = vertex.peer_y; peer[2] = vertex.peer_z;
  end

  // Valid bits of the stages before and after the divider.
  logic [14:1] pv;
  logic [5:1]  kv;
  logic        div_vld;
  logic [Q_W-1:0] div_q;
  side_t       div_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
      kv <= '0;
    end else begin
      pv <= {pv[13:1], start};
      kv <= {kv[4:1], div_vld};
    end
  end

  // Stage 1: view vector and edge vector.
  logic signed [32:0] s1_v [3], s1_e [3];
  logic signed [31:0] s1_n [3];
  side_t              s1_sd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_v[i] <= 33'(eye[i]) - 33'(pos[i]);
      s1_e[i] <= 33'(pos[i]) - 33'(peer[i]);
      s1_n[i] <= nrm[i];
    end
    s1_sd.k1   <= vertex.curv_max;
    s1_sd.k2   <= vertex.curv_min;
    s1_sd.d    <= '0;
    s1_sd.cont <= 1'b0;
    s1_sd.ok   <= 1'b0;
    s1_sd.last <= vertex.last_vertex;
  end

  // Stage 2: v_i * n_i.
  logic signed [64:0] s2_vn [3];
  logic signed [32:0] s2_v [3], s2_e [3];
  logic signed [31:0] s2_n [3];
  side_t              s2_sd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_vn[i] <= 65'(s1_v[i]) * 65'(s1_n[i]);
      s2_v[i]  <= s1_v[i];
      s2_e[i]  <= s1_e[i];
      s2_n[i]  <= s1_n[i];
    end
    s2_sd <= s1_sd;
  end

  // Stage 3: d = v.n, saturated to Q32.32.
  logic signed [66:0] dsum;
  logic signed [63:0] dsat;
  always_comb begin
    dsum = 67'(s2_vn[0]) + 67'(s2_vn[1]) + 67'(s2_vn[2]);
    if (dsum[66:63] == 4'b0000 || dsum[66:63] == 4'b1111) begin
      dsat = dsum[63:0];
    end else begin
      dsat = dsum[66] ? Q64_MIN : Q64_MAX;
    end
  end

  logic signed [32:0] s3_v [3], s3_e [3];
  logic signed [31:0] s3_n [3];
  side_t              s3_sd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_v[i] <= s2_v[i];
      s3_e[i] <= s2_e[i];
      s3_n[i] <= s2_n[i];
    end
    s3_sd <= {s2_sd.k1, s2_sd.k2, dsat, s2_sd.cont, s2_sd.ok, s2_sd.last};
  end

  // Stage 4: contour test and the split product d * n_i.
  // The most negative d has magnitude 2^63, above any limit, so it never passes.
  logic [63:0] dmag;
  assign dmag = s3_sd.d[63] ? 64'(-s3_sd.d) : 64'(s3_sd.d);

  logic signed [64:0] s4_pl [3];
  logic signed [63:0] s4_ph [3];
  logic signed [32:0] s4_v [3], s4_e [3];
  side_t              s4_sd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_pl[i] <= 65'($signed({1'b0, s3_sd.d[31:0]})) * 65'(s3_n[i]);
      s4_ph[i] <= 64'($signed(s3_sd.d[63:32])) * 64'(s3_n[i]);
      s4_v[i]  <= s3_v[i];
      s4_e[i]  <= s3_e[i];
    end
    s4_sd <= {s3_sd.k1, s3_sd.k2, s3_sd.d, (dmag < {1'b0, contour_lim}),
              s3_sd.ok, s3_sd.last};
  end

  // Stage 5: recombine d * n_i.
  logic signed [95:0] s5_dn [3];
  logic signed [32:0] s5_v [3], s5_e [3];
  side_t              s5_sd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s5_dn[i] <= (96'(s4_ph[i]) <<< 32) + 96'(s4_pl[i]);
      s5_v[i]  <= s4_v[i];
      s5_e[i]  <= s4_e[i];
    end
    s5_sd <= s4_sd;
  end

  // Stage 6: w = v * 2^32 - d * n in Q48.48.
  logic signed [96:0] s6_w [3];
  logic signed [32:0] s6_e [3];
  side_t              s6_sd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s6_w[i] <= 97'($signed({s5_v[i], 32'd0})) - 97'(s5_dn[i]);
      s6_e[i] <= s5_e[i];
    end
    s6_sd <= s5_sd;
  end

  // Stage 7: component magnitudes and their OR, whose bit length equals the largest one's.
  logic [32:0] s7_em [3];
  logic [96:0] s7_wm [3];
  logic [2:0]  s7_esg, s7_wsg;
  logic [32:0] s7_eor;
  logic [96:0] s7_wor;
  side_t       s7_sd;
  logic [32:0] em_c [3];
  logic [96:0] wm_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      em_c[i] = s6_e[i][32] ? 33'(-s6_e[i]) : 33'(s6_e[i]);
      wm_c[i] = s6_w[i][96] ? 97'(-s6_w[i]) : 97'(s6_w[i]);
    end
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s7_em[i]  <= em_c[i];
      s7_wm[i]  <= wm_c[i];
      s7_esg[i] <= s6_e[i][32];
      s7_wsg[i] <= s6_w[i][96];
    end
    s7_eor <= em_c[0] | em_c[1] | em_c[2];
    s7_wor <= wm_c[0] | wm_c[1] | wm_c[2];
    s7_sd  <= s6_sd;
  end

  // Stage 8: normalizing shift counts from the bit lengths.
  logic [5:0] le;
  logic [6:0] lw;
  always_comb begin
    le = '0;
    lw = '0;
    for (int i = 0; i < 33; i++) if (s7_eor[i]) le = 6'(i + 1);
    for (int i = 0; i < 97; i++) if (s7_wor[i]) lw = 7'(i + 1);
  end

  logic [1:0]  s8_se;
  logic [6:0]  s8_sw;
  logic [32:0] s8_em [3];
  logic [96:0] s8_wm [3];
  logic [2:0]  s8_esg, s8_wsg;
  side_t       s8_sd;
  always_ff @(posedge clk) begin
    s8_se  <= (le > 6'd30) ? 2'(le - 6'd30) : 2'd0;
    s8_sw  <= (lw > 7'd30) ? 7'(lw - 7'd30) : 7'd0;
    s8_em  <= s7_em;
    s8_wm  <= s7_wm;
    s8_esg <= s7_esg;
    s8_wsg <= s7_wsg;
    s8_sd  <= s7_sd;
  end

  // Stage 9: shift magnitudes below 2^30 and restore the signs.
  logic [29:0] eq_c [3], wq_c [3];
  logic [32:0] esh [3];
  logic [96:0] wsh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      esh[i]  = s8_em[i] >> s8_se;
      wsh[i]  = s8_wm[i] >> s8_sw;
      eq_c[i] = esh[i][29:0];
      wq_c[i] = wsh[i][29:0];
    end
  end

  logic signed [30:0] s9_ne [3], s9_nw [3];
  side_t              s9_sd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s9_ne[i] <= s8_esg[i] ? -$signed({1'b0, eq_c[i]}) : $signed({1'b0, eq_c[i]});
      s9_nw[i] <= s8_wsg[i] ? -$signed({1'b0, wq_c[i]}) : $signed({1'b0, wq_c[i]});
    end
    s9_sd <= s8_sd;
  end

  // Stage 10: the nine small products.
  logic signed [61:0] s10_pd [3], s10_pe [3], s10_pw [3];
  side_t              s10_sd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s10_pd[i] <= 62'(s9_ne[i]) * 62'(s9_nw[i]);
      s10_pe[i] <= 62'(s9_ne[i]) * 62'(s9_ne[i]);
      s10_pw[i] <= 62'(s9_nw[i]) * 62'(s9_nw[i]);
    end
    s10_sd <= s9_sd;
  end

  // Stage 11: e.w, |e|^2 and |w|^2; a zero vector leaves cos^2 undefined.
  logic signed [63:0] dot_c;
  logic [61:0]        ee_c, ww_c;
  always_comb begin
    dot_c = 64'(s10_pd[0]) + 64'(s10_pd[1]) + 64'(s10_pd[2]);
    ee_c  = 62'($unsigned(s10_pe[0])) + 62'($unsigned(s10_pe[1]))
          + 62'($unsigned(s10_pe[2]));
    ww_c  = 62'($unsigned(s10_pw[0])) + 62'($unsigned(s10_pw[1]))
          + 62'($unsigned(s10_pw[2]));
  end

  logic signed [63:0] s11_dot;
  logic [61:0]        s11_ee, s11_ww;
  side_t              s11_sd;
  always_ff @(posedge clk) begin
    s11_dot <= dot_c;
    s11_ee  <= ee_c;
    s11_ww  <= ww_c;
    s11_sd  <= {s10_sd.k1, s10_sd.k2, s10_sd.d, s10_sd.cont,
                (ee_c != '0) && (ww_c != '0), s10_sd.last};
  end

  // Stage 12: |e.w|.
  logic [61:0] s12_dm, s12_ee, s12_ww;
  side_t       s12_sd;
  always_ff @(posedge clk) begin
    s12_dm <= s11_dot[63] ? 62'(-s11_dot) : 62'(s11_dot);
    s12_ee <= s11_ee;
    s12_ww <= s11_ww;
    s12_sd <= s11_sd;
  end

  // Stage 13: 31-bit partial products of (e.w)^2 and |e|^2 |w|^2.
  logic [61:0] s13_a11, s13_a10, s13_a00;
  logic [61:0] s13_b11, s13_b10, s13_b01, s13_b00;
  side_t       s13_sd;
  always_ff @(posedge clk) begin
    s13_a11 <= 62'(s12_dm[61:31]) * 62'(s12_dm[61:31]);
    s13_a10 <= 62'(s12_dm[61:31]) * 62'(s12_dm[30:0]);
    s13_a00 <= 62'(s12_dm[30:0]) * 62'(s12_dm[30:0]);
    s13_b11 <= 62'(s12_ee[61:31]) * 62'(s12_ww[61:31]);
    s13_b10 <= 62'(s12_ee[61:31]) * 62'(s12_ww[30:0]);
    s13_b01 <= 62'(s12_ee[30:0]) * 62'(s12_ww[61:31]);
    s13_b00 <= 62'(s12_ee[30:0]) * 62'(s12_ww[30:0]);
    s13_sd  <= s12_sd;
  end

  // Stage 14: assemble the numerator and denominator.
  logic [NUM_W-1:0] s14_num, s14_den;
  side_t            s14_sd;
  always_ff @(posedge clk) begin
    s14_num <= (NUM_W'(s13_a11) << 62) + (NUM_W'(s13_a10) << 32) + NUM_W'(s13_a00);
    s14_den <= (NUM_W'(s13_b11) << 62) + ((NUM_W'(s13_b10) + NUM_W'(s13_b01)) << 31)
             + NUM_W'(s13_b00);
    s14_sd  <= s13_sd;
  end

  vcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (pv[14]),
    .num      (s14_num),
    .den      (s14_den),
    .in_side  (s14_sd),
    .out_vld  (div_vld),
    .quo      (div_q),
    .out_side (div_side)
  );

  // K1: split products k1 * c and k2 * (1 - c).
  logic [Q_W-1:0] cc;
  assign cc = COS_ONE - div_q;

  logic signed [66:0] k1_l1, k1_l2;
  logic signed [65:0] k1_h1, k1_h2;
  side_t              k1_sd;
  always_ff @(posedge clk) begin
    k1_l1 <= 67'($signed({1'b0, div_side.k1[31:0]})) * 67'($signed({1'b0, div_q}));
    k1_h1 <= 66'($signed(div_side.k1[63:32])) * 66'($signed({1'b0, div_q}));
    k1_l2 <= 67'($signed({1'b0, div_side.k2[31:0]})) * 67'($signed({1'b0, cc}));
    k1_h2 <= 66'($signed(div_side.k2[63:32])) * 66'($signed({1'b0, cc}));
    k1_sd <= div_side;
  end

  // K2: recombine each product.
  logic signed [98:0] k2_s1, k2_s2;
  side_t              k2_sd;
  always_ff @(posedge clk) begin
    k2_s1 <= (99'(k1_h1) <<< 32) + 99'(k1_l1);
    k2_s2 <= (99'(k1_h2) <<< 32) + 99'(k1_l2);
    k2_sd <= k1_sd;
  end

  // K3: sum with the rounding half.
  logic signed [99:0] k3_acc;
  side_t              k3_sd;
  always_ff @(posedge clk) begin
    k3_acc <= 100'(k2_s1) + 100'(k2_s2) + 100'(33'sh0_8000_0000);
    k3_sd  <= k2_sd;
  end

  // K4: drop the fraction and saturate; an undefined cos^2 gives zero.
  logic signed [63:0] k4_kr;
  side_t              k4_sd;
  always_ff @(posedge clk) begin
    if (!k3_sd.ok) begin
      k4_kr <= '0;
    end else if (k3_acc[99:95] == 5'b00000 || k3_acc[99:95] == 5'b11111) begin
      k4_kr <= k3_acc[95:32];
    end else begin
      k4_kr <= k3_acc[99] ? Q64_MIN : Q64_MAX;
    end
    k4_sd <= k3_sd;
  end

  // K5: suggestive test and the output register.
  logic [63:0] krmag;
  assign krmag = k4_kr[63] ? 64'(-k4_kr) : 64'(k4_kr);

  always_ff @(posedge clk) begin
    result.on_contour    <= k4_sd.cont;
    result.on_suggestive <= k4_sd.ok && (k4_kr != Q64_MIN)
                          && (krmag < {1'b0, suggest_lim});
    result.view_dot      <= k4_sd.d;
    result.radial_curv   <= k4_kr;
    result.last_out      <= k4_sd.last;
  end

  assign done = kv[5];

`ifndef NO_ASSERTIONS
  a_contour_not_sat: assert property (@(posedge clk) disable iff (rst)
    done && result.on_contour |-> result.view_dot != Q64_MIN)
    else $error("contour flag set on a saturated view dot");

  a_sugg_not_sat: assert property (@(posedge clk) disable iff (rst)
    done && result.on_suggestive |-> result.radial_curv != Q64_MIN)
    else $error("suggestive flag set on a saturated radial curvature");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    div_vld && div_side.ok |-> div_q <= COS_ONE)
    else $error("cos^2 quotient above one");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    kv[4] && !k4_sd.ok |-> k4_kr == '0)
    else $error("radial curvature not cleared for an undefined cos^2");
`endif

endmodule

// ===== rtl/vcc_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined cos^2 divider
// Restoring division, one quotient bit per stage, floor(num * 2^32 / den).
// ----------------------------------------------------------------------------
module vcc_div
  import vcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [Q_W-1:0]   quo,
  output side_t            out_side
);

  logic [Q_W-1:0]   vld;
  logic [NUM_W-1:0] rem  [Q_W];
  logic [NUM_W-1:0] dv   [Q_W];
  logic [Q_W-1:0]   qt   [Q_W];
  side_t            sd   [Q_W];

  logic [NUM_W:0]   sh   [Q_W];
  logic [NUM_W-1:0] dd   [Q_W];
  logic [Q_W-1:0]   qin  [Q_W];
  side_t            sin  [Q_W];
  logic [Q_W-1:0]   take;

  // The first stage compares without a shift; later ones shift the remainder first.
  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      if (j == 0) begin
        sh[j]  = {1'b0, num};
        dd[j]  = den;
        qin[j] = '0;
        sin[j] = in_side;
      end else begin
        sh[j]  = {rem[j-1], 1'b0};
        dd[j]  = dv[j-1];
        qin[j] = qt[j-1];
        sin[j] = sd[j-1];
      end
      take[j] = (sh[j] >= {1'b0, dd[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Q_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < Q_W; j++) begin
      dv[j]  <= dd[j];
      sd[j]  <= sin[j];
      qt[j]  <= {qin[j][Q_W-2:0], take[j]};
      rem[j] <= take[j] ? NUM_W'(sh[j] - {1'b0, dd[j]}) : sh[j][NUM_W-1:0];
    end
  end

  assign out_vld  = vld[Q_W-1];
  assign quo      = qt[Q_W-1];
  assign out_side = sd[Q_W-1];

endmodule
